// File: rtl/core/msb_pkg.sv
// ----------------------------------------------------------------------------
// msb_pkg
// Shared types and constants of the mono sprite blitter: mode codes, the
// command that passes from the front end to the back end, and back-end states.
// ----------------------------------------------------------------------------
package msb_pkg;

   // Input mode codes.
   localparam logic [2:0] MODE_COPY  = 3'd0;
   localparam logic [2:0] MODE_ZERO  = 3'd1;
   localparam logic [2:0] MODE_ERASE = 3'd2;
   localparam logic [2:0] MODE_XOR   = 3'd3;
   localparam logic [2:0] MODE_VLINE = 3'd4;
   localparam logic [2:0] MODE_READ  = 3'd5;
   localparam logic [2:0] MODE_CLEAR = 3'd6;

   localparam logic [7:0] BYTE_ONES = 8'hff;
   localparam logic [2:0] BIT_MAX   = 3'd7;
   localparam logic [5:0] MAX_WIDTH = 6'd32;
   localparam logic [7:0] ROW_MAX   = 8'd255;

   // Unclipped linear address: (255 + 255) * 64 + 31 + 31 still fits.
   localparam int FULL_W = 15;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      CMD_COPY,
      CMD_ZERO,
      CMD_ERASE,
      CMD_XOR,
      CMD_VLINE,
      CMD_READ,
      CMD_CLEAR,
      CMD_REPORT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [FULL_W-1:0] addr;
      logic              ok;
      logic [7:0]        pix;
      logic              last;
      logic              rng;
      logic [4:0]        count;
      logic [2:0]        top_lo;
      logic [2:0]        bot_lo;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MODIFY,
      BK_READ,
      BK_VL_READ,
      BK_VL_WRITE,
      BK_CLEAR,
      BK_RESULT
   } back_state_type;

endpackage

// File: rtl/core/msb_ram.sv
// ----------------------------------------------------------------------------
// msb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module msb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 7168
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/msb_queue.sv
// ----------------------------------------------------------------------------
// msb_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module msb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  msb_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output msb_pkg::q_head_type head
);
   import msb_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

endmodule

// File: rtl/core/msb_front.sv
// ----------------------------------------------------------------------------
// msb_front
// Front end: accepts requests, walks the sprite position, computes and
// range-checks linear addresses, queueing a command per known-mode request.
// ----------------------------------------------------------------------------
module msb_front #(
   parameter int COLUMNS          = 224,
   parameter int BYTES_PER_COLUMN = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [2:0]       req_mode,
   input  logic [7:0]       req_column,
   input  logic [4:0]       req_row_byte,
   input  logic [5:0]       req_width,
   input  logic [7:0]       req_pixel_byte,
   input  logic             req_last,
   input  logic [7:0]       req_line_top,
   input  logic [7:0]       req_line_bottom,
   input  logic             init_busy,
   input  logic             q_full,
   output logic             push,
   output msb_pkg::cmd_type push_cmd
);
   import msb_pkg::*;

   localparam int STORE = COLUMNS * BYTES_PER_COLUMN;

   logic [4:0]        byte_in_row_ff, byte_in_row_in;
   logic [7:0]        sprite_row_ff, sprite_row_in;
   logic              range_acc_ff, range_acc_in;

   logic              accept, is_sprite, wrap;
   logic [8:0]        mul_in;
   logic [FULL_W-1:0] col_base, sp_addr, rd_addr, vl_base, vl_end;
   logic [5:0]        w_eff;
   logic [4:0]        vl_count;

   assign req_stall = q_full | init_busy;
   assign accept    = req_valid & ~req_stall;
   assign is_sprite = (req_mode <= MODE_XOR);

   // One constant multiplier serves sprite, line and read addressing.
   always_comb begin
      mul_in   = is_sprite ? ({1'b0, req_column} + {1'b0, sprite_row_ff})
                           : {1'b0, req_column};
      col_base = FULL_W'(mul_in * BYTES_PER_COLUMN);
      sp_addr  = col_base + FULL_W'(req_row_byte) + FULL_W'(byte_in_row_ff);
      rd_addr  = col_base + FULL_W'(req_row_byte);
      vl_base  = col_base + FULL_W'(req_line_top[7:3]);
      vl_count = req_line_bottom[7:3] - req_line_top[7:3];
      vl_end   = vl_base + FULL_W'(vl_count);
      if (req_width == '0) begin
         w_eff = 6'd1;
      end else if (req_width > MAX_WIDTH) begin
         w_eff = MAX_WIDTH;
      end else begin
         w_eff = req_width;
      end
      wrap = (({1'b0, byte_in_row_ff} + 6'd1) >= w_eff);
   end

   always_comb begin
      push_cmd        = '0;
      push_cmd.pix    = req_pixel_byte;
      push_cmd.last   = req_last;
      push_cmd.top_lo = req_line_top[2:0];
      push_cmd.bot_lo = req_line_bottom[2:0];
      push            = accept;
      case (req_mode)
         MODE_COPY, MODE_ZERO, MODE_ERASE, MODE_XOR: begin
            push_cmd.kind = cmd_kind_type'(req_mode);
            push_cmd.addr = sp_addr;
            push_cmd.ok   = (sp_addr < FULL_W'(STORE));
            push_cmd.rng  = range_acc_ff | ~push_cmd.ok;
         end
         MODE_VLINE: begin
            if (req_line_top > req_line_bottom) begin
               push_cmd.kind = CMD_REPORT;
               push_cmd.rng  = 1'b1;
            end else begin
               push_cmd.kind  = CMD_VLINE;
               push_cmd.addr  = vl_base;
               push_cmd.count = vl_count;
               push_cmd.rng   = (vl_end >= FULL_W'(STORE));
            end
         end
         MODE_READ: begin
            push_cmd.kind = CMD_READ;
            push_cmd.addr = rd_addr;
            push_cmd.ok   = (rd_addr < FULL_W'(STORE));
         end
         MODE_CLEAR: begin
            push_cmd.kind = CMD_CLEAR;
         end
         default: begin
            push_cmd.kind = CMD_REPORT;
            push          = 1'b0;
         end
      endcase
   end

   always_comb begin
      byte_in_row_in = byte_in_row_ff;
      sprite_row_in  = sprite_row_ff;
      range_acc_in   = range_acc_ff;
      if (accept && is_sprite) begin
         if (req_last) begin
            byte_in_row_in = '0;
            sprite_row_in  = '0;
            range_acc_in   = 1'b0;
         end else begin
            range_acc_in = push_cmd.rng;
            if (wrap) begin
               byte_in_row_in = '0;
               if (sprite_row_ff != ROW_MAX) begin
                  sprite_row_in = sprite_row_ff + 8'd1;
               end
            end else begin
               byte_in_row_in = byte_in_row_ff + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_in_row_ff <= '0;
         sprite_row_ff  <= '0;
         range_acc_ff   <= 1'b0;
      end else begin
         byte_in_row_ff <= byte_in_row_in;
         sprite_row_ff  <= sprite_row_in;
         range_acc_ff   <= range_acc_in;
      end
   end

endmodule

// File: rtl/core/msb_back.sv
// ----------------------------------------------------------------------------
// msb_back
// Back end: owns the framebuffer RAM, runs read-modify-write, line and clear
// sequences, tracks collisions and holds the response register.
// ----------------------------------------------------------------------------
module msb_back #(
   parameter int COLUMNS          = 224,
   parameter int BYTES_PER_COLUMN = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  msb_pkg::q_head_type q,
   output logic                pop,
   output logic                init_busy,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_read_data,
   output logic                rsp_collided,
   output logic                rsp_out_of_range
);
   import msb_pkg::*;

   localparam int STORE  = COLUMNS * BYTES_PER_COLUMN;
   localparam int ADDR_W = $clog2(STORE);

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [4:0]        k_ff, k_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              init_ff, init_in;
   logic              col_acc_ff, col_acc_in;
   logic [7:0]        res_data_ff, res_data_in;
   logic              res_col_ff, res_col_in;
   logic              res_rng_ff, res_rng_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff;
   logic              rsp_col_ff, rsp_rng_ff;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data, new_byte, vl_mask;
   logic [FULL_W-1:0] vl_addr;
   logic              vl_ok, out_free, load, hit;

   msb_ram #(
      .WIDTH (8),
      .DEPTH (STORE)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign load      = (state_ff == BK_RESULT) & out_free;
   assign init_busy = init_ff;

   always_comb begin
      vl_addr = cmd_ff.addr + FULL_W'(k_ff);
      vl_ok   = (vl_addr < FULL_W'(STORE));
      vl_mask = BYTE_ONES;
      if (k_ff == '0) begin
         vl_mask = vl_mask & (BYTE_ONES << cmd_ff.top_lo);
      end
      if (k_ff == cmd_ff.count) begin
         vl_mask = vl_mask & (BYTE_ONES >> (BIT_MAX - cmd_ff.bot_lo));
      end
      case (cmd_ff.kind)
         CMD_COPY:  new_byte = cmd_ff.pix;
         CMD_ZERO:  new_byte = '0;
         CMD_ERASE: new_byte = rd_data & ~cmd_ff.pix;
         default:   new_byte = rd_data ^ cmd_ff.pix;
      endcase
      hit = cmd_ff.ok & (cmd_ff.kind == CMD_XOR) & (new_byte != '0);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q.valid) begin
               case (q.cmd.kind)
                  CMD_COPY, CMD_ZERO, CMD_ERASE, CMD_XOR: state_in = BK_MODIFY;
                  CMD_VLINE:  state_in = BK_VL_READ;
                  CMD_READ:   state_in = BK_READ;
                  CMD_CLEAR:  state_in = BK_CLEAR;
                  default:    state_in = BK_RESULT;
               endcase
            end
         end
         BK_MODIFY:   state_in = cmd_ff.last ? BK_RESULT : BK_IDLE;
         BK_READ:     state_in = BK_RESULT;
         BK_VL_READ:  state_in = BK_VL_WRITE;
         BK_VL_WRITE: state_in = (k_ff == cmd_ff.count) ? BK_RESULT : BK_VL_READ;
         BK_CLEAR: begin
            if (clr_ff == ADDR_W'(STORE - 1)) begin
               state_in = init_ff ? BK_IDLE : BK_RESULT;
            end
         end
         BK_RESULT:   state_in = out_free ? BK_IDLE : BK_RESULT;
         default:     state_in = BK_IDLE;
      endcase
   end

   // Datapath and RAM controls.
   always_comb begin
      pop         = 1'b0;
      cmd_in      = cmd_ff;
      k_in        = k_ff;
      clr_in      = clr_ff;
      init_in     = init_ff;
      col_acc_in  = col_acc_ff;
      res_data_in = res_data_ff;
      res_col_in  = res_col_ff;
      res_rng_in  = res_rng_ff;
      wr_en       = 1'b0;
      wr_addr     = cmd_ff.addr[ADDR_W-1:0];
      wr_data     = new_byte;
      rd_en       = 1'b0;
      rd_addr     = q.cmd.addr[ADDR_W-1:0];
      case (state_ff)
         BK_IDLE: begin
            if (q.valid) begin
               pop         = 1'b1;
               cmd_in      = q.cmd;
               k_in        = '0;
               clr_in      = '0;
               res_data_in = '0;
               res_col_in  = 1'b0;
               res_rng_in  = q.cmd.rng;
               rd_en       = q.cmd.ok & ((q.cmd.kind == CMD_COPY) |
                             (q.cmd.kind == CMD_ZERO) | (q.cmd.kind == CMD_ERASE) |
                             (q.cmd.kind == CMD_XOR) | (q.cmd.kind == CMD_READ));
            end
         end
         BK_MODIFY: begin
            wr_en = cmd_ff.ok;
            if (cmd_ff.last) begin
               res_col_in = col_acc_ff | hit;
               res_rng_in = cmd_ff.rng;
               col_acc_in = 1'b0;
            end else begin
               col_acc_in = col_acc_ff | hit;
            end
         end
         BK_READ: begin
            res_data_in = cmd_ff.ok ? rd_data : '0;
            res_rng_in  = ~cmd_ff.ok;
         end
         BK_VL_READ: begin
            rd_en   = vl_ok;
            rd_addr = vl_addr[ADDR_W-1:0];
         end
         BK_VL_WRITE: begin
            wr_en   = vl_ok;
            wr_addr = vl_addr[ADDR_W-1:0];
            wr_data = rd_data ^ vl_mask;
            k_in    = k_ff + 5'd1;
         end
         BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(STORE - 1)) begin
               init_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         init_ff      <= 1'b1;
         clr_ff       <= '0;
         col_acc_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clr_ff       <= clr_in;
         col_acc_ff   <= col_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      k_ff        <= k_in;
      res_data_ff <= res_data_in;
      res_col_ff  <= res_col_in;
      res_rng_ff  <= res_rng_in;
      if (load) begin
         rsp_data_ff <= res_data_ff;
         rsp_col_ff  <= res_col_ff;
         rsp_rng_ff  <= res_rng_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_collided     = rsp_col_ff;
   assign rsp_out_of_range = rsp_rng_ff;

   a_pop_needs_entry : assert property (@(posedge clock) disable iff (reset)
      pop |-> q.valid)
      else $error("command taken from an empty queue");

   a_no_pop_in_init : assert property (@(posedge clock) disable iff (reset)
      init_ff |-> !pop)
      else $error("command taken during the reset clearing pass");

   a_result_ram_quiet : assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_RESULT) |-> (!wr_en && !rd_en))
      else $error("framebuffer accessed while a response waits");

endmodule

// File: rtl/core/mono_sprite_blitter_unit.sv
// ----------------------------------------------------------------------------
// mono_sprite_blitter_unit
// One-bit-per-pixel framebuffer with sprite blits, XOR collision detection,
// vertical XOR lines, byte reads and screen clearing.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------
//  req_    | in        | req_valid/req_stall| mode, column, row_byte, width,
//          |           |                    | pixel_byte, last, line_top/bottom
//  rsp_    | out       | rsp_valid/rsp_stall| read_data, collided, out_of_range
//
// A sprite byte takes a back-end RAM read, then a write; the final byte of a
// blit also passes the result state to hand over its response. A vertical
// line reads and writes each byte row it touches, a read passes the read
// state, and a clear-screen writes all COLUMNS * BYTES_PER_COLUMN bytes, all
// set by the single framebuffer RAM port pair. After reset a clearing pass
// over all COLUMNS * BYTES_PER_COLUMN bytes zeroes the framebuffer while
// req_stall is held high. A two-entry command queue lets requests keep
// arriving while the back end works or a response is held by rsp_stall.
//
module mono_sprite_blitter_unit #(
   parameter int COLUMNS          = 224,
   parameter int BYTES_PER_COLUMN = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_column,
   input  logic [4:0] req_row_byte,
   input  logic [5:0] req_width,
   input  logic [7:0] req_pixel_byte,
   input  logic       req_last,
   input  logic [7:0] req_line_top,
   input  logic [7:0] req_line_bottom,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_collided,
   output logic       rsp_out_of_range
);
   import msb_pkg::*;

   // Commands flow front end -> queue -> back end.
   logic       push, q_full, pop, init_busy;
   cmd_type    push_cmd;
   q_head_type q_head;

   // The front end owns the sprite walk and the range accumulator, so the
   // address of every command is known before it enters the queue.
   msb_front #(
      .COLUMNS          (COLUMNS),
      .BYTES_PER_COLUMN (BYTES_PER_COLUMN)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_column      (req_column),
      .req_row_byte    (req_row_byte),
      .req_width       (req_width),
      .req_pixel_byte  (req_pixel_byte),
      .req_last        (req_last),
      .req_line_top    (req_line_top),
      .req_line_bottom (req_line_bottom),
      .init_busy       (init_busy),
      .q_full          (q_full),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   // The queue decouples request acceptance from framebuffer work.
   msb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .head     (q_head)
   );

   // The back end holds the framebuffer, the collision accumulator and the
   // response register that drives the rsp_ channel.
   msb_back #(
      .COLUMNS          (COLUMNS),
      .BYTES_PER_COLUMN (BYTES_PER_COLUMN)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q                (q_head),
      .pop              (pop),
      .init_busy        (init_busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_collided     (rsp_collided),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mono_sprite_blitter_unit. A shadow framebuffer and
// a shadow of the blit state predict each response. Stimulus runs in phases:
// directed corner cases, sprite-heavy random traffic, sender hold-offs, field
// noise and a tail with no idling. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import msb_pkg::*;

   localparam int COLS        = 224;
   localparam int BPC         = 32;
   localparam int STORE_BYTES = COLS * BPC;

   // Mode seven has no package name; the block must ignore it.
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   // Random screen clears are costly (a full sweep of the store), so they are
   // rationed across the whole run.
   localparam int CLEAR_BUDGET = 10;

   typedef struct {
      logic [7:0] read_data;
      logic       collided;
      logic       out_of_range;
   } blit_status_t;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [2:0] req_mode         = MODE_COPY;
   logic [7:0] req_column       = 8'h00;
   logic [4:0] req_row_byte     = 5'h00;
   logic [5:0] req_width        = 6'h01;
   logic [7:0] req_pixel_byte   = 8'h00;
   logic       req_last         = 1'b0;
   logic [7:0] req_line_top     = 8'h00;
   logic [7:0] req_line_bottom  = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_collided;
   logic       rsp_out_of_range;

   // Shadow of the framebuffer and of the blit walk held inside the block.
   logic [7:0]  fb_shadow [STORE_BYTES];
   int unsigned blit_byte;
   int unsigned blit_row;
   logic        blit_hit;
   logic        blit_range;

   // Responses still owed by the block, oldest first.
   blit_status_t awaited_rsp [$];

   bit idle_on;
   int stall_left;
   int fault_count;
   int rsp_checked;
   int req_sent;
   int collide_seen;
   int range_seen;
   int clears_sent;

   mono_sprite_blitter_unit #(
      .COLUMNS          (COLS),
      .BYTES_PER_COLUMN (BPC)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_column       (req_column),
      .req_row_byte     (req_row_byte),
      .req_width        (req_width),
      .req_pixel_byte   (req_pixel_byte),
      .req_last         (req_last),
      .req_line_top     (req_line_top),
      .req_line_bottom  (req_line_bottom),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_collided     (rsp_collided),
      .rsp_out_of_range (rsp_out_of_range)
   );

   always #4 clock = ~clock;

   // Works out what one accepted transaction does to the framebuffer and the
   // blit walk, and queues the response it owes, if any.
   task automatic predict_blit(input logic [2:0] mode, input logic [7:0] column,
                               input logic [4:0] row_byte, input logic [5:0] width,
                               input logic [7:0] pix, input logic is_last,
                               input logic [7:0] top, input logic [7:0] bottom);
      int unsigned  addr;
      int unsigned  span;
      int unsigned  b;
      logic [7:0]   mask;
      blit_status_t r;
      bit           owed;
      owed = 1'b0;
      r.read_data    = 8'h00;
      r.collided     = 1'b0;
      r.out_of_range = 1'b0;
      case (mode)
         MODE_COPY, MODE_ZERO, MODE_ERASE, MODE_XOR: begin
            addr = (column + blit_row) * BPC + row_byte + blit_byte;
            if (addr >= STORE_BYTES) begin
               blit_range = 1'b1;
            end else begin
               case (mode)
                  MODE_COPY:  fb_shadow[addr] = pix;
                  MODE_ZERO:  fb_shadow[addr] = 8'h00;
                  MODE_ERASE: fb_shadow[addr] = fb_shadow[addr] & ~pix;
                  default: begin
                     fb_shadow[addr] = fb_shadow[addr] ^ pix;
                     if (fb_shadow[addr] != 8'h00) blit_hit = 1'b1;
                  end
               endcase
            end
            // A width of zero behaves as one; anything wider than a column
            // behaves as a full column.
            span = (width == 6'd0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : width);
            if (blit_byte + 1 >= span) begin
               blit_byte = 0;
               if (blit_row < ROW_MAX) blit_row++;
            end else begin
               blit_byte++;
            end
            if (is_last) begin
               owed = 1'b1;
               r.collided     = blit_hit;
               r.out_of_range = blit_range;
               blit_byte  = 0;
               blit_row   = 0;
               blit_hit   = 1'b0;
               blit_range = 1'b0;
            end
         end
         MODE_VLINE: begin
            owed = 1'b1;
            if (top > bottom) begin
               r.out_of_range = 1'b1;
            end else begin
               for (b = top >> 3; b <= (bottom >> 3); b++) begin
                  mask = BYTE_ONES;
                  if (b == (top >> 3)) mask = mask & (BYTE_ONES << top[2:0]);
                  if (b == (bottom >> 3)) mask = mask & (BYTE_ONES >> (BIT_MAX - bottom[2:0]));
                  addr = column * BPC + b;
                  if (addr >= STORE_BYTES) r.out_of_range = 1'b1;
                  else fb_shadow[addr] = fb_shadow[addr] ^ mask;
               end
            end
         end
         MODE_READ: begin
            owed = 1'b1;
            addr = column * BPC + row_byte;
            if (addr >= STORE_BYTES) r.out_of_range = 1'b1;
            else r.read_data = fb_shadow[addr];
         end
         MODE_CLEAR: begin
            owed = 1'b1;
            foreach (fb_shadow[i]) fb_shadow[i] = 8'h00;
         end
         default: ;
      endcase
      if (owed) begin
         if (r.collided) collide_seen++;
         if (r.out_of_range) range_seen++;
         awaited_rsp.push_back(r);
      end
   endtask

   // Presents one request transaction, holds it until accepted and then
   // records its prediction. Called at a rising edge; returns at the edge of
   // acceptance with req_valid still high.
   task automatic send_req(input logic [2:0] mode, input logic [7:0] column,
                           input logic [4:0] row_byte, input logic [5:0] width,
                           input logic [7:0] pix, input logic is_last,
                           input logic [7:0] top, input logic [7:0] bottom);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_column      <= column;
      req_row_byte    <= row_byte;
      req_width       <= width;
      req_pixel_byte  <= pix;
      req_last        <= is_last;
      req_line_top    <= top;
      req_line_bottom <= bottom;
      // The stall is looked at mid-cycle, where it is settled for the next edge.
      @(negedge clock);
      while (req_stall !== 1'b0) @(negedge clock);
      @(posedge clock);
      predict_blit(mode, column, row_byte, width, pix, is_last, top, bottom);
      req_sent++;
      if (mode == MODE_CLEAR) clears_sent++;
   endtask

   // Sprite origins mostly sit in a narrow band of columns so that blits
   // overlap and XOR blits collide; now and then they run past the end.
   function automatic logic [7:0] pick_column();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 60) return $urandom_range(0, 7);
      if (p < 92) return $urandom_range(0, COLS - 1);
      return $urandom_range(COLS - 24, 255);
   endfunction

   function automatic logic [5:0] pick_width();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 60) return $urandom_range(1, 4);
      if (p < 85) return $urandom_range(5, 32);
      if (p < 95) return $urandom_range(33, 63);
      return 6'd0;
   endfunction

   function automatic logic [7:0] pick_pixel();
      int unsigned p;
      p = $urandom_range(0, 9);
      if (p == 0) return 8'h00;
      if (p == 1) return BYTE_ONES;
      return $urandom_range(0, 255);
   endfunction

   // Well-formed traffic: whole blits of one to ten bytes, sometimes with a
   // stray mode inside, between reads, vertical lines, rare clears and the
   // odd ignored request. Every blit is closed by its last byte.
   task automatic random_traffic(input int unsigned n_items);
      int unsigned done_items;
      int unsigned n_bytes;
      int unsigned pick;
      int unsigned i;
      logic [2:0]  kind;
      logic [2:0]  m;
      logic [7:0]  col;
      logic [4:0]  rb;
      logic [5:0]  w;
      logic [7:0]  t;
      logic [7:0]  bt;
      logic [7:0]  swap;
      done_items = 0;
      while (done_items < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            kind    = $urandom_range(MODE_COPY, MODE_XOR);
            col     = pick_column();
            rb      = $urandom_range(0, 31);
            w       = pick_width();
            n_bytes = $urandom_range(1, 10);
            for (i = 0; i < n_bytes; i++) begin
               m = ($urandom_range(0, 6) == 0) ? $urandom_range(MODE_COPY, MODE_XOR) : kind;
               send_req(m, col, rb, w, pick_pixel(), i == n_bytes - 1,
                        $urandom_range(0, 255), $urandom_range(0, 255));
            end
            done_items += n_bytes;
         end else if (pick < 78 || (pick >= 97 && clears_sent > CLEAR_BUDGET)) begin
            send_req(MODE_READ, pick_column(), $urandom_range(0, 31), $urandom_range(0, 63),
                     $urandom_range(0, 255), $urandom_range(0, 1),
                     $urandom_range(0, 255), $urandom_range(0, 255));
            done_items++;
         end else if (pick < 94) begin
            t  = $urandom_range(0, 255);
            bt = $urandom_range(0, 255);
            // Mostly ordered ends; left as drawn a tenth of the time so that
            // a top below the bottom still turns up.
            if (t > bt && $urandom_range(0, 9) != 0) begin
               swap = t;
               t    = bt;
               bt   = swap;
            end
            send_req(MODE_VLINE, pick_column(), $urandom_range(0, 31), $urandom_range(0, 63),
                     $urandom_range(0, 255), $urandom_range(0, 1), t, bt);
            done_items++;
         end else if (pick < 97) begin
            send_req(MODE_UNUSED, $urandom_range(0, 255), $urandom_range(0, 31),
                     $urandom_range(0, 63), $urandom_range(0, 255), $urandom_range(0, 1),
                     $urandom_range(0, 255), $urandom_range(0, 255));
         end else begin
            send_req(MODE_CLEAR, $urandom_range(0, 255), $urandom_range(0, 31),
                     $urandom_range(0, 63), $urandom_range(0, 255), $urandom_range(0, 1),
                     $urandom_range(0, 255), $urandom_range(0, 255));
            done_items++;
         end
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   // Corner cases: field extremes, every mode, a mixed-mode blit that spills
   // into the next column, zero and oversized widths, writes and reads past
   // the end, the vertical line held to bit seven, a line with its top below
   // its bottom, an ignored mode and a screen clear.
   task automatic test_directed_cases();
      send_req(MODE_READ,  8'd0,   5'd0,  6'd1,  8'h00, 1'b0, 8'd0,   8'd0);
      send_req(MODE_COPY,  8'd0,   5'd0,  6'd1,  8'hff, 1'b1, 8'd0,   8'd0);
      send_req(MODE_READ,  8'd0,   5'd0,  6'd1,  8'h00, 1'b0, 8'd0,   8'd0);
      send_req(MODE_XOR,   8'd0,   5'd0,  6'd1,  8'h0f, 1'b1, 8'd0,   8'd0);
      send_req(MODE_XOR,   8'd0,   5'd0,  6'd1,  8'hf0, 1'b1, 8'd0,   8'd0);
      send_req(MODE_COPY,  8'd10,  5'd31, 6'd2,  8'ha5, 1'b0, 8'd0,   8'd0);
      send_req(MODE_COPY,  8'd10,  5'd31, 6'd2,  8'h5a, 1'b0, 8'd0,   8'd0);
      send_req(MODE_ERASE, 8'd10,  5'd31, 6'd2,  8'h05, 1'b0, 8'd0,   8'd0);
      send_req(MODE_ZERO,  8'd10,  5'd31, 6'd2,  8'hff, 1'b1, 8'd0,   8'd0);
      send_req(MODE_READ,  8'd11,  5'd0,  6'd1,  8'h00, 1'b0, 8'd0,   8'd0);
      send_req(MODE_COPY,  8'd223, 5'd31, 6'd0,  8'h3c, 1'b0, 8'd0,   8'd0);
      send_req(MODE_COPY,  8'd223, 5'd31, 6'd0,  8'hc3, 1'b1, 8'd0,   8'd0);
      send_req(MODE_COPY,  8'd5,   5'd0,  6'd63, 8'h81, 1'b1, 8'd0,   8'd0);
      send_req(MODE_COPY,  8'd255, 5'd31, 6'd32, 8'h7e, 1'b1, 8'd0,   8'd0);
      send_req(MODE_VLINE, 8'd2,   5'd0,  6'd1,  8'h00, 1'b0, 8'd0,   8'd7);
      send_req(MODE_VLINE, 8'd2,   5'd0,  6'd1,  8'h00, 1'b0, 8'd7,   8'd7);
      send_req(MODE_VLINE, 8'd2,   5'd0,  6'd1,  8'h00, 1'b0, 8'd9,   8'd8);
      send_req(MODE_VLINE, 8'd223, 5'd0,  6'd1,  8'h00, 1'b0, 8'd0,   8'd255);
      send_req(MODE_VLINE, 8'd255, 5'd0,  6'd1,  8'h00, 1'b0, 8'd255, 8'd255);
      send_req(MODE_READ,  8'd2,   5'd0,  6'd1,  8'h00, 1'b0, 8'd0,   8'd0);
      send_req(MODE_READ,  8'd224, 5'd0,  6'd1,  8'h00, 1'b0, 8'd0,   8'd0);
      send_req(MODE_READ,  8'd255, 5'd31, 6'd1,  8'h00, 1'b0, 8'd0,   8'd0);
      send_req(MODE_UNUSED, 8'd3,  5'd1,  6'd1,  8'h55, 1'b1, 8'd1,   8'd2);
      send_req(MODE_CLEAR, 8'd0,   5'd0,  6'd1,  8'h00, 1'b0, 8'd0,   8'd0);
      send_req(MODE_READ,  8'd223, 5'd31, 6'd1,  8'h00, 1'b0, 8'd0,   8'd0);
   endtask

   // Sprite-heavy traffic with a stretch in the middle where neither side
   // idles.
   task automatic test_sprite_traffic();
      random_traffic(200);
      idle_on = 1'b0;
      random_traffic(60);
      idle_on = 1'b1;
      random_traffic(190);
   endtask

   // The sender stops until every owed response is back, so the block runs
   // dry and restarts from an empty queue.
   task automatic test_sender_holdoff();
      repeat (4) begin
         random_traffic(6);
         wait_for_drain();
      end
   endtask

   // Unshaped requests: every field at full width, last set at random, so
   // blits run open across other modes and walk past the end.
   task automatic test_field_noise();
      int unsigned done_items;
      logic [2:0]  m;
      done_items = 0;
      while (done_items < 150) begin
         m = $urandom_range(MODE_COPY, MODE_UNUSED);
         if (m == MODE_CLEAR && clears_sent > CLEAR_BUDGET) m = MODE_READ;
         send_req(m, $urandom_range(0, 255), $urandom_range(0, 31), $urandom_range(0, 63),
                  $urandom_range(0, 255), $urandom_range(0, 3) == 0,
                  $urandom_range(0, 255), $urandom_range(0, 255));
         if (m != MODE_UNUSED) done_items++;
      end
   endtask

   // Closing stretch at full rate on both channels.
   task automatic test_quiet_tail();
      idle_on = 1'b0;
      random_traffic(200);
   endtask

   // Receiver: stalls in bursts, each of random length, while idling is on.
   always @(posedge clock) begin
      if (!idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Response checker: a transaction that the coming edge accepts is compared
   // with the oldest owed response. Sampling mid-cycle keeps it clear of the
   // edge at which the handshake signals change.
   always @(negedge clock) begin
      blit_status_t want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_rsp.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected response: data %02h collided %b range %b",
                        rsp_read_data, rsp_collided, rsp_out_of_range);
         end else begin
            want = awaited_rsp.pop_front();
            rsp_checked++;
            if (rsp_read_data !== want.read_data || rsp_collided !== want.collided ||
                rsp_out_of_range !== want.out_of_range) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("response mismatch: expected data %02h collided %b range %b, got data %02h collided %b range %b",
                           want.read_data, want.collided, want.out_of_range,
                           rsp_read_data, rsp_collided, rsp_out_of_range);
            end
         end
      end
   end

   initial begin
      foreach (fb_shadow[i]) fb_shadow[i] = 8'h00;
      blit_byte  = 0;
      blit_row   = 0;
      blit_hit   = 1'b0;
      blit_range = 1'b0;
      idle_on    = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_sprite_traffic();
      test_sender_holdoff();
      test_field_noise();
      test_quiet_tail();

      // Let the last responses come home, then allow the block time to
      // finish any trailing work that owes no response.
      wait_for_drain();
      repeat (64) @(posedge clock);

      $display("Checked %0d responses from %0d requests over copy, zero, erase and XOR blits,",
               rsp_checked, req_sent);
      $display("vertical lines, reads and %0d clears; %0d collisions and %0d range flags.",
               clears_sent, collide_seen, range_seen);
      if (awaited_rsp.size() != 0)
         $display("%0d expected responses never arrived", awaited_rsp.size());
      if (fault_count == 0 && awaited_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d response faults", fault_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run, clearing passes included.
   initial begin
      #8ms;
      $display("timeout with %0d responses outstanding", awaited_rsp.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
